// ----- rtl/hsv_pkg.sv -----
// shared constants, character classes and result type for the host string validator
// no dependencies
package hsv_pkg;

  // limits of the hostname check
  localparam int unsigned MAX_NAME_LEN  = 253;
  localparam int unsigned MAX_LABEL_LEN = 63;

  // saturation limits of the tracking counters
  localparam logic [8:0] TOTAL_SAT  = 9'd511;
  localparam logic [6:0] LABEL_SAT  = 7'd127;
  localparam logic [8:0] OCTET_SAT  = 9'd256;
  localparam logic [8:0] OCTET_MAX  = 9'd255;
  localparam logic [1:0] DIGITS_SAT = 2'd3;
  localparam logic [2:0] COUNT_SAT  = 3'd7;
  localparam logic [2:0] COUNT_IPV4 = 3'd3;
  localparam logic [3:0] POS_SAT    = 4'd15;
  localparam logic [3:0] LH_LEN     = 4'd9;

  // characters
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LOW_L = 8'h6C;

  typedef struct packed {
    logic host_ok;
    logic hostname_ok;
    logic ipv4_ok;
  } hsv_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  // letters of "localhost" by position
  function automatic logic [7:0] lh_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h6C; // l
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h63; // c
      4'd3:    ch = 8'h61; // a
      4'd4:    ch = 8'h6C; // l
      4'd5:    ch = 8'h68; // h
      4'd6:    ch = 8'h6F; // o
      4'd7:    ch = 8'h73; // s
      4'd8:    ch = 8'h74; // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/hsv_track.sv -----
// per-string tracking state and single pass byte update for the host string validator
// depends on hsv_pkg
module hsv_track import hsv_pkg::*; #(
  parameter int unsigned NAME_LIMIT  = MAX_NAME_LEN,
  parameter int unsigned LABEL_LIMIT = MAX_LABEL_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic [7:0]  char_byte,
  input  logic        last_byte,
  output hsv_result_t result
);

  localparam logic [8:0] NAME_MAX  = 9'(NAME_LIMIT);
  localparam logic [6:0] LABEL_MAX = 7'(LABEL_LIMIT);

  logic [8:0] total_length, total_length_next;
  logic [6:0] label_length, label_length_next;
  logic [7:0] previous_byte;
  logic       label_shape_ok, label_shape_ok_next;
  logic       dot_seen, dot_seen_next;
  logic [8:0] octet_value, octet_value_next;
  logic [1:0] octet_digits, octet_digits_next;
  logic [2:0] octet_count, octet_count_next;
  logic       ipv4_shape_ok, ipv4_shape_ok_next;
  logic [3:0] special_match_pos, special_match_pos_next;
  logic       special_match_ok, special_match_ok_next;

  logic        is_dot, is_dash, is_dig, is_aln;
  logic [11:0] scaled;
  logic        ip_ok, special, generic, name_ok;

  assign is_dot  = (char_byte == CH_DOT);
  assign is_dash = (char_byte == CH_DASH);
  assign is_dig  = is_digit(char_byte);
  assign is_aln  = is_alnum(char_byte);

  // octet times ten plus the new digit
  assign scaled = {octet_value, 3'b000} + {2'b00, octet_value, 1'b0} +
                  {8'h00, char_byte[3:0]};

  always_comb begin
    // exact special strings
    if (special_match_pos == 4'd0) begin
      special_match_ok_next = special_match_ok &&
                              ((char_byte == CH_LOW_L) || (char_byte == CH_STAR));
    end else begin
      special_match_ok_next = special_match_ok && (special_match_pos < LH_LEN) &&
                              (char_byte == lh_char(special_match_pos)) &&
                              ((special_match_pos != 4'd1) || (previous_byte == CH_LOW_L));
    end
    special_match_pos_next = (special_match_pos == POS_SAT) ? special_match_pos
                                                           : special_match_pos + 4'd1;

    // hostname labels
    dot_seen_next = dot_seen || is_dot;
    if (is_dot) begin
      label_shape_ok_next = label_shape_ok && (label_length != 7'd0) &&
                            (previous_byte != CH_DASH);
      label_length_next   = 7'd0;
    end else begin
      label_shape_ok_next = label_shape_ok && (label_length < LABEL_MAX) &&
                            ((label_length != 7'd0) || is_aln) &&
                            (is_aln || is_dash) &&
                            !(is_dash && (previous_byte == CH_DASH));
      label_length_next   = (label_length == LABEL_SAT) ? label_length
                                                        : label_length + 7'd1;
    end

    // dotted decimal parts
    octet_value_next   = octet_value;
    octet_digits_next  = octet_digits;
    octet_count_next   = octet_count;
    ipv4_shape_ok_next = 1'b0;
    if (is_dot) begin
      ipv4_shape_ok_next = ipv4_shape_ok && (octet_digits != 2'd0) &&
                           (octet_count < COUNT_IPV4);
      octet_count_next   = (octet_count == COUNT_SAT) ? octet_count
                                                      : octet_count + 3'd1;
      octet_value_next   = 9'd0;
      octet_digits_next  = 2'd0;
    end else if (is_dig) begin
      if (octet_value <= OCTET_MAX) begin
        octet_value_next = (scaled > 12'(OCTET_MAX)) ? OCTET_SAT : scaled[8:0];
      end
      ipv4_shape_ok_next = ipv4_shape_ok &&
                           !((octet_digits != 2'd0) && (octet_value == 9'd0)) &&
                           (octet_value_next <= OCTET_MAX);
      octet_digits_next  = (octet_digits == DIGITS_SAT) ? octet_digits
                                                        : octet_digits + 2'd1;
    end

    total_length_next = (total_length == TOTAL_SAT) ? total_length
                                                    : total_length + 9'd1;

    // verdict for a string that ends on this byte
    ip_ok   = ipv4_shape_ok_next && (octet_count_next == COUNT_IPV4) &&
              (octet_digits_next != 2'd0);
    special = special_match_ok_next &&
              ((special_match_pos_next == LH_LEN) ||
               ((special_match_pos_next == 4'd1) && (char_byte == CH_STAR)));
    generic = (total_length < NAME_MAX) && dot_seen_next && label_shape_ok_next &&
              !is_dot && !is_dash && !ip_ok;
    name_ok = (special || generic) && !ip_ok;

    result.ipv4_ok     = ip_ok;
    result.hostname_ok = name_ok;
    result.host_ok     = ip_ok || name_ok;
  end

  always_ff @(posedge clk) begin
    if (rst || (adv && last_byte)) begin
      total_length      <= 9'd0;
      label_length      <= 7'd0;
      previous_byte     <= 8'h00;
      label_shape_ok    <= 1'b1;
      dot_seen          <= 1'b0;
      octet_value       <= 9'd0;
      octet_digits      <= 2'd0;
      octet_count       <= 3'd0;
      ipv4_shape_ok     <= 1'b1;
      special_match_pos <= 4'd0;
      special_match_ok  <= 1'b1;
    end else if (adv) begin
      total_length      <= total_length_next;
      label_length      <= label_length_next;
      previous_byte     <= char_byte;
      label_shape_ok    <= label_shape_ok_next;
      dot_seen          <= dot_seen_next;
      octet_value       <= octet_value_next;
      octet_digits      <= octet_digits_next;
      octet_count       <= octet_count_next;
      ipv4_shape_ok     <= ipv4_shape_ok_next;
      special_match_pos <= special_match_pos_next;
      special_match_ok  <= special_match_ok_next;
    end
  end

  // string state starts over after a closing byte
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (adv && last_byte) |=> (total_length == 9'd0) && (label_length == 7'd0) &&
                           (octet_count == 3'd0) && special_match_ok && ipv4_shape_ok)
    else $error("tracking state not cleared after last byte");

  // match position and total length advance together until saturation
  a_pos_total: assert property (@(posedge clk) disable iff (rst)
    (total_length < 9'd15) |-> (special_match_pos == total_length[3:0]))
    else $error("special match position out of step with length");

  // an empty part holds no value
  a_octet_empty: assert property (@(posedge clk) disable iff (rst)
    (octet_digits == 2'd0) |-> (octet_value == 9'd0))
    else $error("octet value without digits");

  // a label never outgrows the string
  a_label_len: assert property (@(posedge clk) disable iff (rst)
    {2'b00, label_length} <= total_length)
    else $error("label longer than string");

endmodule

// ----- rtl/host_string_validator_core.sv -----
// top level of the host string validator: input register, tracker, result register
// depends on hsv_pkg and hsv_track
//
// Checks a host string streamed one byte per transfer on s_axis, with s_axis_tlast on
// the final byte, and answers once per string on m_axis: bit 0 says the string is a
// dotted IPv4 address (four decimal parts, no leading zeros, each 0..255), bit 1 that
// it is a hostname ("localhost", "*", or a dotted name of at most NAME_LIMIT bytes,
// 253 by default, whose labels are 1..LABEL_LIMIT bytes, 63 by default, alphanumeric
// or hyphen, alphanumeric at both ends, no double hyphen) and not an address, bit 2
// that either holds. Bytes that are not last give no transfer on m_axis. One byte is
// taken every cycle unless a closing byte is held back: the work on a byte is a single
// pass of small counter and flag logic between the input register and the result
// register, so the verdict of a string is loaded into the result register when its
// last byte advances out of the input register, and leaves on m_axis from there. Only
// a closing byte waits for the result register, and only while an earlier result is
// still held there; other bytes keep flowing while a result waits.
module host_string_validator_core import hsv_pkg::*; #(
  parameter int unsigned NAME_LIMIT  = MAX_NAME_LEN,
  parameter int unsigned LABEL_LIMIT = MAX_LABEL_LEN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] char_byte
  input  logic       s_axis_tlast,  // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] ipv4_ok, [1] hostname_ok, [2] host_ok, [7:3] zero
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // result register
  logic        out_valid;
  hsv_result_t out_result;

  hsv_result_t result;
  logic        out_free;
  logic        adv;

  // a result slot is free when empty or being drained this cycle
  assign out_free = !out_valid || m_axis_tready;
  // non-closing bytes never need the result slot
  assign adv      = s1_valid && (!s1_last || out_free);
  assign s_axis_tready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_byte <= s_axis_tdata;
      s1_last <= s_axis_tlast;
    end
  end

  hsv_track #(
    .NAME_LIMIT  (NAME_LIMIT),
    .LABEL_LIMIT (LABEL_LIMIT)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .char_byte (s1_byte),
    .last_byte (s1_last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // capture the verdict of a closing byte
  always_ff @(posedge clk) begin
    if (adv && s1_last) begin
      out_result <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b00000, out_result.host_ok, out_result.hostname_ok,
                          out_result.ipv4_ok};

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for host_string_validator_core: directed table plus random host strings
// depends on hsv_pkg (result type) and the core; predicts untyped verdicts with its own checker
module testbench import hsv_pkg::*;;

  typedef logic [7:0] text_q_t[$];

  // shapes of generated host strings
  typedef enum int {
    FORM_ADDR,
    FORM_NAME,
    FORM_NEAR_SPECIAL,
    FORM_NOISE,
    FORM_LONG
  } host_form_e;

  // one row of the directed table; lead is an optional raw byte sent before text
  typedef struct {
    string       text;
    logic [7:0]  lead;
    bit          has_lead;
    bit          has_typed;
    hsv_result_t typed;
  } probe_row_t;

  localparam int HALF_PERIOD    = 6;
  localparam int RANDOM_BYTES   = 900;
  localparam int IDLE_PERCENT   = 24;
  localparam int DRAIN_CYCLES   = 6;
  localparam int NAME_LIMIT     = 253;
  localparam int LABEL_LIMIT    = 63;
  localparam int OCTET_TOP      = 255;

  // verdicts typed into the directed table: {host_ok, hostname_ok, ipv4_ok}
  localparam hsv_result_t VERDICT_NONE = 3'b000;
  localparam hsv_result_t VERDICT_ADDR = 3'b101;
  localparam hsv_result_t VERDICT_NAME = 3'b110;

  localparam logic [7:0]  KEY_DOT   = 8'h2E;
  localparam logic [7:0]  KEY_DASH  = 8'h2D;
  localparam logic [7:0]  KEY_STAR  = 8'h2A;
  localparam logic [7:0]  KEY_ZERO  = 8'h30;
  localparam logic [7:0]  KEY_NINE  = 8'h39;
  localparam logic [7:0]  KEY_LOW_A = 8'h61;
  localparam logic [7:0]  KEY_LOW_Z = 8'h7A;
  localparam logic [7:0]  KEY_UP_A  = 8'h41;
  localparam logic [7:0]  KEY_UP_Z  = 8'h5A;
  localparam logic [7:0]  KEY_LOW_L = 8'h6C;
  localparam logic [71:0] LH_TEXT   = "localhost";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] char_byte
  logic       s_axis_tlast = 1'b0;   // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [0] ipv4_ok, [1] hostname_ok, [2] host_ok, [7:3] zero

  // checker state, mirrors what the block tracks per string
  logic [8:0] seen_len;
  logic [6:0] lbl_len;
  logic [7:0] last_char;
  logic       lbl_ok;
  logic       any_dot;
  logic [8:0] part_val;
  logic [1:0] part_digits;
  logic [2:0] part_count;
  logic       addr_ok;
  logic [3:0] match_pos;
  logic       match_ok;

  hsv_result_t verdicts_due[$];
  probe_row_t  probe_rows[$];

  bit calm = 1'b0;  // when set neither side idles
  int miss_count    = 0;
  int bytes_sent    = 0;
  int strings_sent  = 0;
  int verdicts_seen = 0;
  int addr_hits     = 0;
  int name_hits     = 0;

  always #(HALF_PERIOD) clk = ~clk;

  host_string_validator_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic bit digit_char(input logic [7:0] c);
    return c >= KEY_ZERO && c <= KEY_NINE;
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return digit_char(c) || (c >= KEY_LOW_A && c <= KEY_LOW_Z) ||
           (c >= KEY_UP_A && c <= KEY_UP_Z);
  endfunction

  function automatic void clear_checker();
    seen_len    = '0;
    lbl_len     = '0;
    last_char   = '0;
    lbl_ok      = 1'b1;
    any_dot     = 1'b0;
    part_val    = '0;
    part_digits = '0;
    part_count  = '0;
    addr_ok     = 1'b1;
    match_pos   = '0;
    match_ok    = 1'b1;
  endfunction

  // advance the checker by one byte; on the closing byte return the verdict and restart
  function automatic hsv_result_t absorb_byte(input logic [7:0] c, input logic fin,
                                              output bit closes);
    logic [3:0]  pos;
    logic [7:0]  prev;
    logic [7:0]  want;
    logic [8:0]  prior;
    int          grown;
    logic        addr, special, dotted, named;
    hsv_result_t verdict;
    pos   = match_pos;
    prev  = last_char;
    prior = seen_len;
    want  = (pos < 9) ? LH_TEXT[8 * (8 - int'(pos)) +: 8] : 8'h00;

    // exact strings "localhost" and "*"
    if (pos == 0) begin
      if (!(c == KEY_LOW_L || c == KEY_STAR)) match_ok = 1'b0;
    end else if (!(pos < 9 && c == want && (pos != 1 || prev == KEY_LOW_L))) begin
      match_ok = 1'b0;
    end

    // hostname labels
    if (c == KEY_DOT) begin
      any_dot = 1'b1;
      if (lbl_len == 0 || prev == KEY_DASH) lbl_ok = 1'b0;
      lbl_len = '0;
    end else begin
      if (lbl_len >= LABEL_LIMIT) lbl_ok = 1'b0;
      if (lbl_len == 0 && !word_char(c)) lbl_ok = 1'b0;
      if (!word_char(c) && c != KEY_DASH) lbl_ok = 1'b0;
      if (c == KEY_DASH && prev == KEY_DASH) lbl_ok = 1'b0;
      if (lbl_len != 7'd127) lbl_len = lbl_len + 1'b1;
    end

    // dotted decimal parts, value pinned at 256 once too big
    if (c == KEY_DOT) begin
      if (part_digits == 0 || part_count >= 3) addr_ok = 1'b0;
      if (part_count != 3'd7) part_count = part_count + 1'b1;
      part_val    = '0;
      part_digits = '0;
    end else if (digit_char(c)) begin
      if (part_digits >= 1 && part_val == 0) addr_ok = 1'b0;
      if (part_val <= OCTET_TOP) begin
        grown    = int'(part_val) * 10 + int'(c - KEY_ZERO);
        part_val = (grown > OCTET_TOP) ? 9'd256 : grown[8:0];
      end
      if (part_val > OCTET_TOP) addr_ok = 1'b0;
      if (part_digits != 2'd3) part_digits = part_digits + 1'b1;
    end else begin
      addr_ok = 1'b0;
    end

    if (seen_len != 9'd511) seen_len = seen_len + 1'b1;
    if (match_pos != 4'd15) match_pos = match_pos + 1'b1;
    last_char = c;

    closes  = fin;
    verdict = VERDICT_NONE;
    if (fin) begin
      addr    = addr_ok && part_count == 3 && part_digits != 0;
      special = match_ok && (match_pos == 9 || (match_pos == 1 && c == KEY_STAR));
      dotted  = prior < NAME_LIMIT && any_dot && lbl_ok && c != KEY_DOT &&
                c != KEY_DASH && !addr;
      named   = (special || dotted) && !addr;
      verdict.ipv4_ok     = addr;
      verdict.hostname_ok = named;
      verdict.host_ok     = addr || named;
      clear_checker();
    end
    return verdict;
  endfunction

  task automatic report_miss(input string note);
    $display("[%0t] %s", $time, note);
    miss_count++;
  endtask

  function automatic bit take_idle();
    return !calm && $urandom_range(99) < IDLE_PERCENT;
  endfunction

  function automatic void add_probe(input string text, input logic [7:0] lead,
                                    input bit has_lead, input bit has_typed,
                                    input hsv_result_t typed);
    probe_row_t row;
    row.text      = text;
    row.lead      = lead;
    row.has_lead  = has_lead;
    row.has_typed = has_typed;
    row.typed     = typed;
    probe_rows.insert(probe_rows.size(), row);
  endfunction

  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(61);
    if (r < 10) return KEY_ZERO + 8'(r);
    if (r < 36) return KEY_LOW_A + 8'(r - 10);
    return KEY_UP_A + 8'(r - 36);
  endfunction

  function automatic logic [7:0] pick_odd_char();
    case ($urandom_range(4))
      0:       return KEY_DOT;
      1:       return KEY_DASH;
      2:       return KEY_ZERO;
      3:       return pick_word_char();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // build one random host string; most are well formed, some get one byte spoiled
  function automatic text_q_t compose_string();
    text_q_t    q;
    host_form_e form;
    int         r, parts, val, run, lim, target;
    string      digits;
    r = $urandom_range(199);
    form = (r < 60) ? FORM_ADDR : (r < 124) ? FORM_NAME : (r < 146) ? FORM_NEAR_SPECIAL :
           (r < 196) ? FORM_NOISE : FORM_LONG;
    case (form)
      FORM_ADDR: begin
        parts = ($urandom_range(99) < 80) ? 4 : $urandom_range(1, 9);
        for (int p = 0; p < parts; p++) begin
          if (p > 0) q.insert(q.size(), KEY_DOT);
          r = $urandom_range(99);
          if (r < 50) val = $urandom_range(OCTET_TOP);
          else if (r < 75) begin
            case ($urandom_range(5))
              0:       val = 0;
              1:       val = 9;
              2:       val = 99;
              3:       val = 100;
              4:       val = 255;
              default: val = 256;
            endcase
          end else if (r < 90) val = $urandom_range(256, 999);
          else val = $urandom_range(1000, 99999);
          // leading zero, or an empty part
          if ($urandom_range(99) < 6) q.insert(q.size(), KEY_ZERO);
          if ($urandom_range(99) >= 4) begin
            digits = $sformatf("%0d", val);
            for (int k = 0; k < digits.len(); k++) q.insert(q.size(), digits[k]);
          end
        end
      end
      FORM_NAME: begin
        parts = $urandom_range(1, 4);
        for (int p = 0; p < parts; p++) begin
          if (p > 0) q.insert(q.size(), KEY_DOT);
          run = ($urandom_range(99) < 8) ? $urandom_range(60, 66) : $urandom_range(1, 8);
          for (int k = 0; k < run; k++) begin
            if (k == 0 || k == run - 1 || q[q.size() - 1] == KEY_DASH ||
                $urandom_range(99) >= 15) q.insert(q.size(), pick_word_char());
            else q.insert(q.size(), KEY_DASH);
          end
        end
      end
      FORM_NEAR_SPECIAL: begin
        if ($urandom_range(99) < 60) begin
          for (int k = 8; k >= 0; k--) q.insert(q.size(), LH_TEXT[8 * k +: 8]);
        end else begin
          q.insert(q.size(), KEY_STAR);
        end
        case ($urandom_range(4))
          0:       ;
          1:       if (q.size() > 1) void'(q.pop_back());
          2:       q.insert(q.size(), ($urandom_range(1)) ? KEY_STAR : pick_word_char());
          3:       q[$urandom_range(q.size() - 1)] = pick_odd_char();
          default: q.push_front(($urandom_range(1)) ? KEY_LOW_L : KEY_STAR);
        endcase
      end
      FORM_NOISE: begin
        run = $urandom_range(1, 6);
        for (int k = 0; k < run; k++)
          q.insert(q.size(), ($urandom_range(1)) ? 8'($urandom_range(255)) : pick_odd_char());
      end
      default: begin
        // long names around the total length limit, sometimes past the counter range
        target = ($urandom_range(99) < 75) ? $urandom_range(250, 257)
                                           : $urandom_range(258, 530);
        lim    = ($urandom_range(99) < 80) ? $urandom_range(55, 63) : $urandom_range(64, 130);
        run    = 0;
        while (q.size() < target) begin
          if (run == lim) begin
            q.insert(q.size(), KEY_DOT);
            run = 0;
          end else begin
            q.insert(q.size(), pick_word_char());
            run++;
          end
        end
        if (q[q.size() - 1] == KEY_DOT) q[q.size() - 1] = KEY_LOW_A;
      end
    endcase
    // an address made only of empty parts still needs one byte
    if (q.size() == 0) q.insert(0, KEY_ZERO);
    if (form != FORM_NOISE && form != FORM_NEAR_SPECIAL && $urandom_range(99) < 12)
      q[$urandom_range(q.size() - 1)] = pick_odd_char();
    return q;
  endfunction

  // one byte on the slave side: random idle cycles, then hold until the transfer
  task automatic push_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (take_idle()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input text_q_t txt, input bit has_typed, input hsv_result_t typed);
    hsv_result_t forecast;
    bit          closes;
    for (int k = 0; k < txt.size(); k++) begin
      push_byte(txt[k], k == txt.size() - 1);
      forecast = absorb_byte(txt[k], k == txt.size() - 1, closes);
      if (closes) verdicts_due.insert(verdicts_due.size(), has_typed ? typed : forecast);
    end
    strings_sent++;
  endtask

  // master side stalls at random
  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // compare every verdict transfer against the oldest pending one
  always @(posedge clk) begin
    hsv_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = hsv_result_t'(m_axis_tdata[2:0]);
      verdicts_seen++;
      if (verdicts_due.size() == 0) begin
        report_miss($sformatf("verdict %0d: transfer 0x%02h with no string pending",
                              verdicts_seen, m_axis_tdata));
      end else begin
        want = verdicts_due.pop_front();
        if (got.ipv4_ok != want.ipv4_ok)
          report_miss($sformatf("verdict %0d: ipv4_ok %0b, expected %0b",
                                verdicts_seen, got.ipv4_ok, want.ipv4_ok));
        if (got.hostname_ok != want.hostname_ok)
          report_miss($sformatf("verdict %0d: hostname_ok %0b, expected %0b",
                                verdicts_seen, got.hostname_ok, want.hostname_ok));
        if (got.host_ok != want.host_ok)
          report_miss($sformatf("verdict %0d: host_ok %0b, expected %0b",
                                verdicts_seen, got.host_ok, want.host_ok));
        if (m_axis_tdata[7:3] != 5'd0)
          report_miss($sformatf("verdict %0d: pad bits 0x%02h, expected zero",
                                verdicts_seen, m_axis_tdata[7:3]));
        if (want.ipv4_ok) addr_hits++;
        if (want.hostname_ok) name_hits++;
      end
    end
  end

  initial begin
    text_q_t txt;
    int      random_count;
    clear_checker();

    // directed table: exact strings, extremes, and strings that each break one rule
    add_probe("*",               8'h00, 0, 1, VERDICT_NAME);
    add_probe("localhost",       8'h00, 0, 1, VERDICT_NAME);
    add_probe("1.2.3.4",         8'h00, 0, 1, VERDICT_ADDR);
    add_probe("255.255.255.255", 8'h00, 0, 1, VERDICT_ADDR);
    add_probe("0.0.0.0",         8'h00, 0, 1, VERDICT_ADDR);
    add_probe("a",               8'h00, 0, 1, VERDICT_NONE);
    add_probe(".",               8'h00, 0, 1, VERDICT_NONE);
    add_probe("a..b",            8'h00, 0, 1, VERDICT_NONE);
    add_probe("",                8'h00, 1, 1, VERDICT_NONE);
    add_probe("",                8'hFF, 1, 1, VERDICT_NONE);
    add_probe("a-b.c",           8'h00, 0, 1, VERDICT_NAME);
    add_probe(".com",            8'hFF, 1, 0, VERDICT_NONE);
    add_probe("256.1.1.1",       8'h00, 0, 0, VERDICT_NONE);
    add_probe("01.2.3.4",        8'h00, 0, 0, VERDICT_NONE);
    add_probe("1.2.3.04",        8'h00, 0, 0, VERDICT_NONE);
    add_probe("1.2.3",           8'h00, 0, 0, VERDICT_NONE);
    add_probe("1.2.3.4.5",       8'h00, 0, 0, VERDICT_NONE);
    add_probe("a--b.c",          8'h00, 0, 0, VERDICT_NONE);
    add_probe("-a.b",            8'h00, 0, 0, VERDICT_NONE);
    add_probe("a-.b",            8'h00, 0, 0, VERDICT_NONE);
    add_probe("a.b.",            8'h00, 0, 0, VERDICT_NONE);
    add_probe("Localhost",       8'h00, 0, 0, VERDICT_NONE);
    add_probe("localhostx",      8'h00, 0, 0, VERDICT_NONE);
    add_probe("**",              8'h00, 0, 0, VERDICT_NONE);
    add_probe("9Z.x-0",          8'h00, 0, 0, VERDICT_NONE);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i]) begin
      txt.delete();
      if (probe_rows[i].has_lead) txt.insert(txt.size(), probe_rows[i].lead);
      for (int k = 0; k < probe_rows[i].text.len(); k++)
        txt.insert(txt.size(), probe_rows[i].text[k]);
      send_text(txt, probe_rows[i].has_typed, probe_rows[i].typed);
    end

    // random strings until the byte budget is used, with one stretch where neither side idles
    random_count = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      calm = random_count >= 15 && random_count < 30;
      send_text(compose_string(), 0, VERDICT_NONE);
      random_count++;
    end
    calm = 1'b0;

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d strings in %0d bytes, %0d verdicts checked",
             strings_sent, bytes_sent, verdicts_seen);
    $display("expected addresses %0d, expected hostnames %0d, mismatches %0d",
             addr_hits, name_hits, miss_count);
    if (miss_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(1200000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- host_string_validator_core.f -----
rtl/hsv_pkg.sv
rtl/hsv_track.sv
rtl/host_string_validator_core.sv
verif/testbench.sv
